FILE: hdl/apts_pkg.sv
// Package for the affinity priority task scheduler: sizes, item structs, codes.
// No dependencies.
`timescale 1ns / 1ps
package apts_pkg;

    localparam int CORE_COUNT     = 4;
    localparam int NUM_PRIORITIES = 4;
    localparam int FIFO_DEPTH     = 16;
    localparam int CORE_BITS      = 2;
    localparam int PRIO_BITS      = 2;
    localparam int PTR_BITS       = 4;
    localparam int FILL_BITS      = 5;
    localparam int LEN_BITS       = 7;
    localparam int QUEUE_COUNT    = CORE_COUNT * NUM_PRIORITIES;
    localparam int QUEUE_BITS     = CORE_BITS + PRIO_BITS;
    localparam int STORE_BITS     = QUEUE_BITS + PTR_BITS;
    localparam int PCT_RESET      = 25;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED   = 2'd0;
    localparam logic [1:0] ST_REJECTED   = 2'd1;
    localparam logic [1:0] ST_DISPATCHED = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] task_id;
        logic [1:0] priority_req;
        logic [3:0] affinity;
        logic [1:0] core;
        logic [7:0] live_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] target_core;
        logic [7:0] out_task;
        logic [1:0] out_priority;
    } out_item_t;

    // classified work for the back end
    typedef struct packed {
        logic                  cmd;
        logic [7:0]            task_id;
        logic [PRIO_BITS-1:0]  prio;
        logic [CORE_BITS-1:0]  core;
        logic [CORE_COUNT-1:0] mask;
        logic                  affine;
        logic [7:0]            live_count;
    } job_t;

endpackage

FILE: hdl/apts_front.sv
// Front end: accepts items, classifies them and buffers them in a two-entry queue.
// Depends on apts_pkg.
`timescale 1ns / 1ps
module apts_front
    import apts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_item_t in_item,
    input  logic     in_valid,
    output logic     in_ready,
    output job_t     job,
    output logic     job_valid,
    input  logic     job_ready
);

    job_t       q_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    job_t       j;

    always_comb
    begin
        j.cmd        = in_item.cmd;
        j.task_id    = in_item.task_id;
        j.prio       = in_item.priority_req;
        j.core       = in_item.core;
        j.mask       = in_item.affinity;
        j.affine     = in_item.affinity[in_item.core];
        j.live_count = in_item.live_count;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            q_reg[wr_reg] <= j;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wr_reg <= ~wr_reg;
            end
            if (job_valid && job_ready)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(job_valid && job_ready);
        end
    end

endmodule

FILE: hdl/apts_back.sv
// Back end: share test, core choice, FIFO update, result register.
// Depends on apts_pkg.
`timescale 1ns / 1ps
module apts_back
    import apts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [6:0] share_limit_pct,
    input  job_t      job,
    input  logic      job_valid,
    output logic      job_ready,
    output out_item_t out_item,
    output logic      out_valid,
    input  logic      out_ready
);

    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_DONE = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] store [1 << STORE_BITS];
    logic [PTR_BITS-1:0]  head_reg [QUEUE_COUNT];
    logic [PTR_BITS-1:0]  tail_reg [QUEUE_COUNT];
    logic [FILL_BITS-1:0] fill_reg [QUEUE_COUNT];
    logic [LEN_BITS-1:0]  len_reg  [CORE_COUNT];
    job_t      job_reg;
    out_item_t res_reg;
    logic      res_valid_reg;
    logic [7:0] rd_data_reg;
    logic       pend_reg;
    logic       load;

    // exec phase signals
    logic [14:0] lhs;
    logic [14:0] rhs;
    logic        migrate;
    logic [CORE_BITS-1:0] best;
    logic [LEN_BITS-1:0]  best_len;
    logic                 found;
    logic [CORE_BITS-1:0] tgt;
    logic [QUEUE_BITS-1:0] eq;
    logic [QUEUE_BITS-1:0] dq;
    logic                  dfound;
    logic [PRIO_BITS-1:0]  dprio;

    always_comb
    begin
        lhs = 15'(len_reg[job_reg.core]) * 15'd100;
        rhs = 15'(share_limit_pct) * 15'(job_reg.live_count);
        // share > pct  <=>  floor(100L/live) > pct  <=>  100L >= (pct+1)*live
        migrate = !job_reg.affine
               || (job_reg.live_count != 8'd0 && lhs >= rhs + 15'(job_reg.live_count));
        best     = '0;
        best_len = '0;
        found    = 1'b0;
        for (int c = 0; c < CORE_COUNT; c++)
        begin
            if (job_reg.mask[c] && (!found || len_reg[c] < best_len))
            begin
                best     = CORE_BITS'(c);
                best_len = len_reg[c];
                found    = 1'b1;
            end
        end
        tgt    = migrate ? best : job_reg.core;
        eq     = {tgt, job_reg.prio};
        dfound = 1'b0;
        dprio  = '0;
        for (int p = 0; p < NUM_PRIORITIES; p++)
        begin
            if (fill_reg[{job_reg.core, PRIO_BITS'(p)}] != '0)
            begin
                dfound = 1'b1;
                dprio  = PRIO_BITS'(p);
            end
        end
        dq = {job_reg.core, dprio};
    end

    // take a job when idle with no read pending, once the result slot is free or being drained
    assign job_ready = (state_reg == S_DONE) && !pend_reg && (!res_valid_reg || out_ready);
    assign load      = job_valid && job_ready;

    always_comb
    begin
        unique case (state_reg)
            S_EXEC:  state_next = S_DONE;
            S_DONE:  state_next = load ? S_EXEC : S_DONE;
            default: state_next = S_DONE;
        endcase
    end

    assign out_item  = res_reg;
    assign out_valid = res_valid_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
        if (state_reg == S_EXEC)
        begin
            rd_data_reg <= store[{dq, head_reg[dq]}];
            if (job_reg.cmd == CMD_ENQ && fill_reg[eq] != FILL_BITS'(FIFO_DEPTH))
            begin
                store[{eq, tail_reg[eq]}] <= job_reg.task_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_DONE;
            res_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            res_reg       <= '0;
            for (int q = 0; q < QUEUE_COUNT; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                fill_reg[q] <= '0;
            end
            for (int c = 0; c < CORE_COUNT; c++)
            begin
                len_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (state_reg == S_EXEC)
            begin
                if (job_reg.cmd == CMD_ENQ)
                begin
                    res_reg.target_core  <= tgt;
                    res_reg.out_task     <= '0;
                    res_reg.out_priority <= '0;
                    res_valid_reg        <= 1'b1;
                    if (fill_reg[eq] == FILL_BITS'(FIFO_DEPTH))
                    begin
                        res_reg.status <= ST_REJECTED;
                    end
                    else
                    begin
                        res_reg.status <= ST_ENQUEUED;
                        tail_reg[eq]   <= tail_reg[eq] + 1'b1;
                        fill_reg[eq]   <= fill_reg[eq] + 1'b1;
                        len_reg[tgt]   <= len_reg[tgt] + 1'b1;
                    end
                end
                else if (dfound)
                begin
                    pend_reg             <= 1'b1;
                    res_reg.status       <= ST_DISPATCHED;
                    res_reg.target_core  <= job_reg.core;
                    res_reg.out_priority <= dprio;
                    head_reg[dq]         <= head_reg[dq] + 1'b1;
                    fill_reg[dq]         <= fill_reg[dq] - 1'b1;
                    if (len_reg[job_reg.core] != '0)
                    begin
                        len_reg[job_reg.core] <= len_reg[job_reg.core] - 1'b1;
                    end
                end
                else
                begin
                    res_reg.status       <= ST_EMPTY;
                    res_reg.target_core  <= job_reg.core;
                    res_reg.out_task     <= '0;
                    res_reg.out_priority <= '0;
                    res_valid_reg        <= 1'b1;
                end
            end
            else if (pend_reg)
            begin
                // read data arrives in the cycle after the pop
                pend_reg         <= 1'b0;
                res_reg.out_task <= rd_data_reg;
                res_valid_reg    <= 1'b1;
            end
        end
    end

endmodule

FILE: hdl/affinity_priority_task_scheduler.sv
// Affinity priority task scheduler: one FIFO per core and priority level.
// Usage:
//   in_valid/in_ready carry one in_item_t; one out_item_t answers each item on
//   out_valid/out_ready, in order. cfg_valid/cfg_ready write share_limit_pct
//   (reset 25); write it only while the block is idle.
//   An enqueue stays on its core unless the core is outside the affinity mask
//   or holds more than the share limit of live tasks; then it goes to the
//   masked core with the shortest queue. A dequeue pops the highest priority.
// Flow:
//   A two-entry front queue accepts items; the back end takes one item, does
//   the FIFO read-modify-write in its exec state and, on a dispatch, then
//   waits for the registered task store read. It takes no new item before
//   the last one's result is written, and then only while the result slot
//   is free or being drained.
// Reset clears all FIFO pointers, fill counts and core lengths at once.
// A stalled receiver holds the result; the front queue keeps taking items
// until it is full.
// Depends on apts_pkg, apts_front, apts_back.
`timescale 1ns / 1ps
module affinity_priority_task_scheduler
    import apts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      in_valid,
    output logic      in_ready,
    output out_item_t out_item,
    output logic      out_valid,
    input  logic      out_ready,
    input  logic [6:0] cfg_data,
    input  logic      cfg_valid,
    output logic      cfg_ready
);

    logic [6:0] pct_reg;
    job_t       job;
    logic       job_valid, job_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg <= 7'(PCT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            pct_reg <= cfg_data;
        end
    end

    apts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    apts_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .share_limit_pct (pct_reg),
        .job             (job),
        .job_valid       (job_valid),
        .job_ready       (job_ready),
        .out_item        (out_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready)
    );

endmodule

FILE: hdl/apts_checker.sv
// Port checker for the affinity priority task scheduler, bound to the top level.
// Depends on apts_pkg.
`timescale 1ns / 1ps
module apts_checker
    import apts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_deq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_ENQUEUED || out_item.status == ST_REJECTED)
        |-> out_item.out_task == '0 && out_item.out_priority == '0)
        else $error("enqueue result carries task");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_EMPTY |-> out_item.out_task == '0)
        else $error("empty result carries task");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_ready && !out_valid)
        else $error("not idle after reset");

endmodule

bind affinity_priority_task_scheduler apts_checker u_apts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

FILE: tb/tb_top.sv
// Testbench for the affinity priority task scheduler: random and directed
// enqueue/dequeue items checked in order against a queue-level scheduler model.
// Depends on apts_pkg and affinity_priority_task_scheduler.
`timescale 1ns / 1ps

class sched_scoreboard;
    int unsigned share_pct;
    bit [7:0]    slots[4][4][$];
    int unsigned core_len[4];
    apts_pkg::out_item_t pending[$];
    int unsigned mismatches;
    int unsigned checked;

    function void clear();
        share_pct = apts_pkg::PCT_RESET;
        foreach (slots[c, p]) slots[c][p].delete();
        foreach (core_len[c]) core_len[c] = 0;
        pending.delete();
        mismatches = 0;
        checked = 0;
    endfunction

    function apts_pkg::out_item_t schedule(apts_pkg::in_item_t it);
        apts_pkg::out_item_t r;
        int unsigned tgt;
        int unsigned share;
        bit          move;
        bit          found;
        r = '0;
        if (it.cmd == apts_pkg::CMD_ENQ) begin
            tgt = it.core;
            move = !it.affinity[it.core];
            if (!move && it.live_count != 0) begin
                share = (100 * core_len[it.core]) / it.live_count;
                if (share > share_pct) move = 1;
            end
            if (move) begin
                tgt = 0;
                found = 0;
                for (int c = 0; c < 4; c++)
                    if (it.affinity[c] && (!found || core_len[c] < core_len[tgt])) begin
                        tgt = c;
                        found = 1;
                    end
            end
            r.target_core = 2'(tgt);
            if (slots[tgt][it.priority_req].size() >= 16)
                r.status = apts_pkg::ST_REJECTED;
            else begin
                r.status = apts_pkg::ST_ENQUEUED;
                slots[tgt][it.priority_req].push_back(it.task_id);
                core_len[tgt]++;
            end
        end else begin
            r.target_core = it.core;
            r.status = apts_pkg::ST_EMPTY;
            for (int p = 3; p >= 0; p--)
                if (r.status == apts_pkg::ST_EMPTY && slots[it.core][p].size() != 0) begin
                    r.status = apts_pkg::ST_DISPATCHED;
                    r.out_task = slots[it.core][p].pop_front();
                    r.out_priority = 2'(p);
                    if (core_len[it.core] > 0) core_len[it.core]--;
                end
        end
        return r;
    endfunction

    function void note_input(apts_pkg::in_item_t it);
        pending.push_back(schedule(it));
    endfunction

    function void check_result(apts_pkg::out_item_t got);
        apts_pkg::out_item_t exp;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        exp = pending.pop_front();
        if (got.status !== exp.status || got.target_core !== exp.target_core ||
            got.out_task !== exp.out_task || got.out_priority !== exp.out_priority) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
        end
    endfunction
endclass

module tb_top;
    import apts_pkg::*;

    logic       clk;
    logic       rst_n;
    in_item_t   in_item;
    logic       in_valid;
    logic       in_ready;
    out_item_t  out_item;
    logic       out_valid;
    logic       out_ready;
    logic [6:0] cfg_data;
    logic       cfg_valid;
    logic       cfg_ready;
    bit         quiet;
    int unsigned sent;

    sched_scoreboard sb;

    affinity_priority_task_scheduler uut (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_item), .in_valid(in_valid), .in_ready(in_ready),
        .out_item(out_item), .out_valid(out_valid), .out_ready(out_ready),
        .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // result side: random stall bursts, check on handshake
    initial
    begin
        int unsigned gap;
        gap = 0;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) sb.check_result(out_item);
            if (gap > 0) begin
                gap--;
                out_ready <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 9) - 1;
                out_ready <= 0;
            end else
                out_ready <= 1;
        end
    end

    task automatic send_item(in_item_t it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_item <= it;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note_input(it);
        sent++;
    endtask

    task automatic write_share(int unsigned pct);
        int unsigned lim;
        lim = 0;
        in_valid <= 0;
        while (sb.pending.size() != 0 && lim < 100000) begin
            @(posedge clk);
            lim++;
        end
        repeat (6) @(posedge clk);
        cfg_data <= 7'(pct);
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        sb.share_pct = pct & 127;
        cfg_valid <= 0;
    endtask

    function automatic in_item_t make_item(bit c, int unsigned core, int unsigned pr,
                                           int unsigned aff, int unsigned live);
        in_item_t it;
        it.cmd = c;
        it.task_id = 8'($urandom_range(0, 255));
        it.priority_req = 2'(pr);
        it.affinity = 4'(aff);
        it.core = 2'(core);
        it.live_count = 8'(live);
        return it;
    endfunction

    function automatic in_item_t random_item();
        int unsigned live;
        live = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255);
        if ($urandom_range(0, 3) == 0) live = $urandom_range(1, 40);
        return make_item($urandom_range(0, 99) < 45, $urandom_range(0, 3),
                         $urandom_range(0, 3), $urandom_range(0, 15), live);
    endfunction

    initial
    begin
        in_item_t it;
        int unsigned lim;
        sb = new();
        sb.clear();
        quiet = 0;
        sent = 0;
        in_item = '0;
        in_valid = 0;
        cfg_data = '0;
        cfg_valid = 0;
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty dequeues on every core
        for (int c = 0; c < 4; c++) send_item(make_item(CMD_DEQ, c, 0, 0, 0));
        // home core, zero live count, empty mask, full mask, extremes
        send_item(make_item(CMD_ENQ, 0, 3, 4'hF, 0));
        send_item(make_item(CMD_ENQ, 1, 0, 4'h0, 255));
        send_item(make_item(CMD_ENQ, 2, 2, 4'h8, 1));
        send_item(make_item(CMD_ENQ, 3, 1, 4'h6, 1));
        it = make_item(CMD_ENQ, 0, 3, 4'hF, 0);
        it.task_id = 8'hFF;
        send_item(it);
        it.task_id = 8'h00;
        it.live_count = 8'hFF;
        send_item(it);
        // fill one FIFO past depth to get rejects
        for (int i = 0; i < 18; i++) send_item(make_item(CMD_ENQ, 1, 2, 4'h2, 0));
        for (int c = 0; c < 4; c++) send_item(make_item(CMD_DEQ, c, 0, 0, 0));

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: write_share(0);
                1: write_share(100);
                2: write_share(127);
                3: write_share($urandom_range(1, 99));
                4: write_share(50);
                5: write_share(25);
                default: write_share($urandom_range(0, 127));
            endcase
            if (ph == 6) quiet = 1;
            for (int i = 0; i < 200; i++) send_item(random_item());
        end
        in_valid <= 0;

        lim = 0;
        while (sb.pending.size() != 0 && lim < 100000) begin
            @(posedge clk);
            lim++;
        end
        repeat (20) @(posedge clk);
        $display("%0d items sent, %0d results checked over seven share settings",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: files.f
hdl/apts_pkg.sv
hdl/apts_front.sv
hdl/apts_back.sv
hdl/affinity_priority_task_scheduler.sv
hdl/apts_checker.sv
tb/tb_top.sv
